/* rtl/core/hid_report_descriptor_parser_defines.svh */
// Assertion macros shared by the HID descriptor parser RTL.
// No dependencies; included by modules that carry concurrent checks.
`ifndef HID_REPORT_DESCRIPTOR_PARSER_DEFINES_SVH
`define HID_REPORT_DESCRIPTOR_PARSER_DEFINES_SVH

// Clocked property check, disabled while reset is low.
`define HRDP_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// At most one of a group of strobes high in any cycle.
`define HRDP_ASSERT_ONEHOT0(lbl, clk, rstn, sig, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) $onehot0(sig)) else $error(msg);

`endif

/* rtl/core/hrdp_pkg.sv */
// Shared types, codes and helpers for the HID report descriptor parser.
// No dependencies.
package hrdp_pkg;

    localparam int STACK_DEPTH_DEF = 4;
    localparam int MAX_USAGES_DEF  = 16;
    localparam int NUM_COUNTS      = 768;
    localparam int CNT_AW          = 10;

    localparam logic [2:0] KIND_FIELD   = 3'd0;
    localparam logic [2:0] KIND_USAGE   = 3'd1;
    localparam logic [2:0] KIND_DONE    = 3'd2;
    localparam logic [2:0] KIND_TRUNC   = 3'd3;
    localparam logic [2:0] KIND_UNDERF  = 3'd4;
    localparam logic [2:0] KIND_OVERF   = 3'd5;
    localparam logic [2:0] KIND_USE_OVF = 3'd6;

    localparam logic [1:0] DIR_INPUT   = 2'd0;
    localparam logic [1:0] DIR_OUTPUT  = 2'd1;
    localparam logic [1:0] DIR_FEATURE = 2'd2;

    localparam logic [1:0] TYPE_MAIN   = 2'd0;
    localparam logic [1:0] TYPE_GLOBAL = 2'd1;
    localparam logic [1:0] TYPE_LOCAL  = 2'd2;

    localparam logic [3:0] TAG_LONG    = 4'hF;
    localparam logic [3:0] TAG_INPUT   = 4'h8;
    localparam logic [3:0] TAG_OUTPUT  = 4'h9;
    localparam logic [3:0] TAG_FEATURE = 4'hB;
    localparam logic [3:0] G_PAGE  = 4'h0;
    localparam logic [3:0] G_LMIN  = 4'h1;
    localparam logic [3:0] G_LMAX  = 4'h2;
    localparam logic [3:0] G_SIZE  = 4'h7;
    localparam logic [3:0] G_IDENT = 4'h8;
    localparam logic [3:0] G_COUNT = 4'h9;
    localparam logic [3:0] G_PUSH  = 4'hA;
    localparam logic [3:0] G_POP   = 4'hB;
    localparam logic [3:0] L_USAGE = 4'h0;
    localparam logic [3:0] L_UMIN  = 4'h1;
    localparam logic [3:0] L_UMAX  = 4'h2;

    typedef enum logic [1:0] {
        PH_PREFIX, PH_SHORT, PH_LONGHDR, PH_LONGSKIP
    } phase_t;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_DECODE, ST_RDCNT, ST_FIELD, ST_MUL,
        ST_UPD, ST_USE_RD, ST_USE, ST_ERR, ST_END
    } ctrl_state_t;

    typedef struct packed {
        logic take;
        logic step;
        logic rd_cnt;
        logic ld_field;
        logic mul;
        logic upd;
        logic rd_use;
        logic ld_use;
        logic ld_err;
        logic ld_end;
        logic clr_locals;
        logic soft_rst;
        logic clr_wr;
    } dp_cmd_t;

    typedef struct packed {
        logic main_fire;
        logic err_fire;
        logic last;
        logic clr_done;
        logic out_free;
        logic use_pending;
        logic use_more;
    } dp_status_t;

    function automatic logic [2:0] data_len(input logic [1:0] code);
        data_len = (code == 2'd3) ? 3'd4 : {1'b0, code};
    endfunction

endpackage

/* rtl/core/hrdp_datapath.sv */
// Datapath of the HID descriptor parser: item decode, global stack, usage
// memory, per-report bit count memory and result register. Uses hrdp_pkg.
module hrdp_datapath #(
    parameter int STACK_DEPTH = hrdp_pkg::STACK_DEPTH_DEF,
    parameter int MAX_USAGES  = hrdp_pkg::MAX_USAGES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  hrdp_pkg::dp_cmd_t    cmd,
    output hrdp_pkg::dp_status_t st,
    input  logic [7:0]           s_tdata,
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [239:0]         m_tdata,
    output logic [2:0]           m_tuser,
    output logic                 m_tlast
);

    localparam int SpW   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int UiW   = (MAX_USAGES > 1) ? $clog2(MAX_USAGES) : 1;
    localparam int FillW = $clog2(MAX_USAGES + 1);

    logic [7:0]  byte_reg;
    logic        last_reg;
    hrdp_pkg::phase_t phase_reg, phase_next;
    logic [7:0]  left_reg, left_next;
    logic [7:0]  prefix_reg, prefix_next;
    logic [31:0] acc_reg, acc_next;
    logic        open_c, open_reg;
    logic [2:0]  err_kind_reg;
    logic [1:0]  dir_reg;

    logic [SpW-1:0] sp_reg;
    logic [15:0] page_stk  [STACK_DEPTH];
    logic [31:0] lmin_stk  [STACK_DEPTH];
    logic [31:0] lmax_stk  [STACK_DEPTH];
    logic [31:0] size_stk  [STACK_DEPTH];
    logic [31:0] count_stk [STACK_DEPTH];
    logic [7:0]  ident_stk [STACK_DEPTH];

    logic [31:0] use_mem [MAX_USAGES];
    logic [31:0] use_q;
    logic [FillW-1:0] fill_reg, use_idx_reg;
    logic [FillW:0]   use_idx_inc;
    logic [31:0] rlow_reg, rhigh_reg;

    logic [15:0] cnt_mem [hrdp_pkg::NUM_COUNTS];
    logic [15:0] cnt_q;
    logic [hrdp_pkg::CNT_AW-1:0] cnt_addr, clr_addr_reg;
    logic [63:0] prod_reg;
    logic [64:0] total;
    logic [15:0] total_sat;

    logic        item_fire;
    logic [7:0]  item_pfx;
    logic [31:0] item_val, item_sval;
    logic [1:0]  itype, pos;
    logic [3:0]  itag;
    logic [2:0]  ilen, plen;
    logic        is_main, is_iof, is_global, is_local;
    logic        push_ovf, pop_unf, use_ovf;
    logic [1:0]  main_dir;
    logic [2:0]  err_kind_c;
    logic [SpW:0] sp_inc;

    logic        out_valid_reg, out_last_reg;
    logic [2:0]  out_kind_reg;
    logic [233:0] out_data_reg;

    logic [15:0] page_cur;
    logic [31:0] lmin_cur, lmax_cur, size_cur, count_cur;
    logic [7:0]  ident_cur;

    assign page_cur  = page_stk[sp_reg];
    assign lmin_cur  = lmin_stk[sp_reg];
    assign lmax_cur  = lmax_stk[sp_reg];
    assign size_cur  = size_stk[sp_reg];
    assign count_cur = count_stk[sp_reg];
    assign ident_cur = ident_stk[sp_reg];

    // byte-level parse step
    always_comb begin
        phase_next  = phase_reg;
        left_next   = left_reg;
        prefix_next = prefix_reg;
        acc_next    = acc_reg;
        open_c      = 1'b0;
        item_fire   = 1'b0;
        item_pfx    = byte_reg;
        item_val    = '0;
        plen        = hrdp_pkg::data_len(prefix_reg[1:0]);
        pos         = 2'(plen - left_reg[2:0]);
        case (phase_reg)
            hrdp_pkg::PH_PREFIX: begin
                prefix_next = byte_reg;
                acc_next    = '0;
                if (byte_reg[7:4] == hrdp_pkg::TAG_LONG) begin
                    phase_next = hrdp_pkg::PH_LONGHDR;
                    left_next  = 8'd2;
                    open_c     = 1'b1;
                end else if (byte_reg[1:0] == 2'd0) begin
                    item_fire = 1'b1;
                end else begin
                    phase_next = hrdp_pkg::PH_SHORT;
                    left_next  = {5'd0, hrdp_pkg::data_len(byte_reg[1:0])};
                    open_c     = 1'b1;
                end
            end
            hrdp_pkg::PH_SHORT: begin
                acc_next  = acc_reg | (32'(byte_reg) << {pos, 3'b000});
                left_next = left_reg - 8'd1;
                if (left_next == 8'd0) begin
                    phase_next = hrdp_pkg::PH_PREFIX;
                    item_fire  = 1'b1;
                    item_pfx   = prefix_reg;
                    item_val   = acc_next;
                end else begin
                    open_c = 1'b1;
                end
            end
            hrdp_pkg::PH_LONGHDR: begin
                if (left_reg == 8'd2) begin
                    acc_next  = {24'd0, byte_reg};
                    left_next = 8'd1;
                    open_c    = 1'b1;
                end else begin
                    left_next = acc_reg[7:0];
                    if (left_next == 8'd0) begin
                        phase_next = hrdp_pkg::PH_PREFIX;
                    end else begin
                        phase_next = hrdp_pkg::PH_LONGSKIP;
                        open_c     = 1'b1;
                    end
                end
            end
            default: begin
                left_next = left_reg - 8'd1;
                if (left_next == 8'd0) begin
                    phase_next = hrdp_pkg::PH_PREFIX;
                end else begin
                    open_c = 1'b1;
                end
            end
        endcase
    end

    // item decode
    always_comb begin
        itype = item_pfx[3:2];
        itag  = item_pfx[7:4];
        ilen  = hrdp_pkg::data_len(item_pfx[1:0]);
        if (ilen == 3'd1 && item_val[7]) begin
            item_sval = item_val | 32'hFFFF_FF00;
        end else if (ilen == 3'd2 && item_val[15]) begin
            item_sval = item_val | 32'hFFFF_0000;
        end else begin
            item_sval = item_val;
        end
        is_main   = item_fire && itype == hrdp_pkg::TYPE_MAIN;
        is_global = item_fire && itype == hrdp_pkg::TYPE_GLOBAL;
        is_local  = item_fire && itype == hrdp_pkg::TYPE_LOCAL;
        is_iof    = is_main && (itag == hrdp_pkg::TAG_INPUT || itag == hrdp_pkg::TAG_OUTPUT
                                || itag == hrdp_pkg::TAG_FEATURE);
        case (itag)
            hrdp_pkg::TAG_INPUT:  main_dir = hrdp_pkg::DIR_INPUT;
            hrdp_pkg::TAG_OUTPUT: main_dir = hrdp_pkg::DIR_OUTPUT;
            default:              main_dir = hrdp_pkg::DIR_FEATURE;
        endcase
        sp_inc   = {1'b0, sp_reg} + 1'b1;
        push_ovf = is_global && itag == hrdp_pkg::G_PUSH
                   && sp_inc >= (SpW+1)'(STACK_DEPTH);
        pop_unf  = is_global && itag == hrdp_pkg::G_POP && sp_reg == '0;
        use_ovf  = is_local && itag == hrdp_pkg::L_USAGE
                   && fill_reg >= FillW'(MAX_USAGES);
        if (push_ovf) begin
            err_kind_c = hrdp_pkg::KIND_OVERF;
        end else if (pop_unf) begin
            err_kind_c = hrdp_pkg::KIND_UNDERF;
        end else begin
            err_kind_c = hrdp_pkg::KIND_USE_OVF;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            byte_reg <= s_tdata;
            last_reg <= s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.soft_rst) begin
            phase_reg    <= hrdp_pkg::PH_PREFIX;
            left_reg     <= '0;
            prefix_reg   <= '0;
            acc_reg      <= '0;
            open_reg     <= 1'b0;
            err_kind_reg <= hrdp_pkg::KIND_DONE;
            dir_reg      <= hrdp_pkg::DIR_INPUT;
            sp_reg       <= '0;
            for (int i = 0; i < STACK_DEPTH; i++) begin
                page_stk[i]  <= '0;
                lmin_stk[i]  <= '0;
                lmax_stk[i]  <= '0;
                size_stk[i]  <= '0;
                count_stk[i] <= '0;
                ident_stk[i] <= '0;
            end
        end else if (cmd.step) begin
            phase_reg    <= phase_next;
            left_reg     <= left_next;
            prefix_reg   <= prefix_next;
            acc_reg      <= acc_next;
            open_reg     <= open_c;
            err_kind_reg <= err_kind_c;
            if (is_iof) begin
                dir_reg <= main_dir;
            end
            if (is_global) begin
                case (itag)
                    hrdp_pkg::G_PAGE:  page_stk[sp_reg]  <= item_val[15:0];
                    hrdp_pkg::G_LMIN:  lmin_stk[sp_reg]  <= item_sval;
                    hrdp_pkg::G_LMAX:  lmax_stk[sp_reg]  <= item_sval;
                    hrdp_pkg::G_SIZE:  size_stk[sp_reg]  <= item_val;
                    hrdp_pkg::G_IDENT: ident_stk[sp_reg] <= item_val[7:0];
                    hrdp_pkg::G_COUNT: count_stk[sp_reg] <= item_val;
                    hrdp_pkg::G_PUSH: begin
                        if (!push_ovf) begin
                            page_stk[sp_inc[SpW-1:0]]  <= page_cur;
                            lmin_stk[sp_inc[SpW-1:0]]  <= lmin_cur;
                            lmax_stk[sp_inc[SpW-1:0]]  <= lmax_cur;
                            size_stk[sp_inc[SpW-1:0]]  <= size_cur;
                            count_stk[sp_inc[SpW-1:0]] <= count_cur;
                            ident_stk[sp_inc[SpW-1:0]] <= ident_cur;
                            sp_reg <= sp_inc[SpW-1:0];
                        end
                    end
                    hrdp_pkg::G_POP: begin
                        if (!pop_unf) begin
                            sp_reg <= sp_reg - 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // local state
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.soft_rst || cmd.clr_locals
            || (cmd.step && is_main && !is_iof)) begin
            fill_reg    <= '0;
            rlow_reg    <= '0;
            rhigh_reg   <= '0;
            use_idx_reg <= '0;
        end else begin
            if (cmd.step && is_local) begin
                case (itag)
                    hrdp_pkg::L_USAGE: begin
                        if (!use_ovf) begin
                            fill_reg <= fill_reg + 1'b1;
                        end
                    end
                    hrdp_pkg::L_UMIN: rlow_reg  <= item_val;
                    hrdp_pkg::L_UMAX: rhigh_reg <= item_val;
                    default: ;
                endcase
            end
            if (cmd.ld_use) begin
                use_idx_reg <= use_idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.step && is_local && itag == hrdp_pkg::L_USAGE && !use_ovf) begin
            use_mem[fill_reg[UiW-1:0]] <= item_val;
        end
        if (cmd.rd_use) begin
            use_q <= use_mem[use_idx_reg[UiW-1:0]];
        end
    end

    // bit count memory
    assign cnt_addr  = {dir_reg, ident_cur};
    assign total     = {49'd0, cnt_q} + {1'b0, prod_reg};
    assign total_sat = (total > 65'd65535) ? 16'hFFFF : total[15:0];

    always_ff @(posedge aclk) begin
        if (cmd.clr_wr) begin
            cnt_mem[clr_addr_reg] <= '0;
        end else if (cmd.upd) begin
            cnt_mem[cnt_addr] <= total_sat;
        end
        if (cmd.rd_cnt) begin
            cnt_q <= cnt_mem[cnt_addr];
        end
        if (cmd.mul) begin
            prod_reg <= 64'(size_cur) * 64'(count_cur);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.soft_rst) begin
            clr_addr_reg <= '0;
        end else if (cmd.clr_wr) begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    // result register
    assign use_idx_inc = {1'b0, use_idx_reg} + 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.ld_field || cmd.ld_use || cmd.ld_err || cmd.ld_end) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.ld_field || cmd.ld_use) begin
            out_kind_reg <= cmd.ld_field ? hrdp_pkg::KIND_FIELD : hrdp_pkg::KIND_USAGE;
            out_last_reg <= cmd.ld_field ? (!last_reg && fill_reg == '0)
                                         : (!last_reg && !st.use_more);
            out_data_reg <= {lmax_cur, lmin_cur,
                             cmd.ld_field ? rhigh_reg : 32'(use_idx_reg),
                             cmd.ld_field ? rlow_reg : use_q,
                             page_cur, count_cur, size_cur, cnt_q, ident_cur, dir_reg};
        end else if (cmd.ld_err) begin
            out_kind_reg <= err_kind_reg;
            out_last_reg <= !last_reg;
            out_data_reg <= '0;
        end else if (cmd.ld_end) begin
            out_kind_reg <= open_reg ? hrdp_pkg::KIND_TRUNC : hrdp_pkg::KIND_DONE;
            out_last_reg <= 1'b1;
            out_data_reg <= '0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {6'd0, out_data_reg};

    assign st.main_fire   = is_iof;
    assign st.err_fire    = push_ovf || pop_unf || use_ovf;
    assign st.last        = last_reg;
    assign st.clr_done    = clr_addr_reg == hrdp_pkg::CNT_AW'(hrdp_pkg::NUM_COUNTS - 1);
    assign st.out_free    = !out_valid_reg || m_tready;
    assign st.use_pending = fill_reg != '0;
    assign st.use_more    = use_idx_inc < {1'b0, fill_reg};

endmodule

/* rtl/core/hrdp_ctrl.sv */
// Sequencing state machine of the HID descriptor parser.
// Uses hrdp_pkg and hid_report_descriptor_parser_defines.svh.
`include "hid_report_descriptor_parser_defines.svh"
module hrdp_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  hrdp_pkg::dp_status_t st,
    output hrdp_pkg::dp_cmd_t    cmd
);

    hrdp_pkg::ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= hrdp_pkg::ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            hrdp_pkg::ST_CLEAR:  if (st.clr_done) state_next = hrdp_pkg::ST_IDLE;
            hrdp_pkg::ST_IDLE:   if (s_tvalid) state_next = hrdp_pkg::ST_DECODE;
            hrdp_pkg::ST_DECODE: begin
                if (st.main_fire) begin
                    state_next = hrdp_pkg::ST_RDCNT;
                end else if (st.err_fire) begin
                    state_next = hrdp_pkg::ST_ERR;
                end else if (st.last) begin
                    state_next = hrdp_pkg::ST_END;
                end else begin
                    state_next = hrdp_pkg::ST_IDLE;
                end
            end
            hrdp_pkg::ST_RDCNT:  state_next = hrdp_pkg::ST_FIELD;
            hrdp_pkg::ST_FIELD:  if (st.out_free) state_next = hrdp_pkg::ST_MUL;
            hrdp_pkg::ST_MUL:    state_next = hrdp_pkg::ST_UPD;
            hrdp_pkg::ST_UPD: begin
                if (st.use_pending) begin
                    state_next = hrdp_pkg::ST_USE_RD;
                end else begin
                    state_next = st.last ? hrdp_pkg::ST_END : hrdp_pkg::ST_IDLE;
                end
            end
            hrdp_pkg::ST_USE_RD: state_next = hrdp_pkg::ST_USE;
            hrdp_pkg::ST_USE: begin
                if (st.out_free) begin
                    if (st.use_more) begin
                        state_next = hrdp_pkg::ST_USE_RD;
                    end else begin
                        state_next = st.last ? hrdp_pkg::ST_END : hrdp_pkg::ST_IDLE;
                    end
                end
            end
            hrdp_pkg::ST_ERR: begin
                if (st.out_free) begin
                    state_next = st.last ? hrdp_pkg::ST_END : hrdp_pkg::ST_IDLE;
                end
            end
            hrdp_pkg::ST_END:    if (st.out_free) state_next = hrdp_pkg::ST_CLEAR;
            default:             state_next = hrdp_pkg::ST_CLEAR;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            hrdp_pkg::ST_CLEAR:  cmd.clr_wr = 1'b1;
            hrdp_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                cmd.take = s_tvalid;
            end
            hrdp_pkg::ST_DECODE: cmd.step = 1'b1;
            hrdp_pkg::ST_RDCNT:  cmd.rd_cnt = 1'b1;
            hrdp_pkg::ST_FIELD:  cmd.ld_field = st.out_free;
            hrdp_pkg::ST_MUL:    cmd.mul = 1'b1;
            hrdp_pkg::ST_UPD: begin
                cmd.upd        = 1'b1;
                cmd.clr_locals = !st.use_pending;
            end
            hrdp_pkg::ST_USE_RD: cmd.rd_use = 1'b1;
            hrdp_pkg::ST_USE: begin
                cmd.ld_use     = st.out_free;
                cmd.clr_locals = st.out_free && !st.use_more;
            end
            hrdp_pkg::ST_ERR:    cmd.ld_err = st.out_free;
            hrdp_pkg::ST_END: begin
                cmd.ld_end   = st.out_free;
                cmd.soft_rst = st.out_free;
            end
            default: ;
        endcase
    end

    `HRDP_ASSERT(a_take_then_decode, aclk, aresetn, cmd.take |=> state_reg == hrdp_pkg::ST_DECODE, "accepted byte not decoded next cycle")
    `HRDP_ASSERT(a_end_then_clear, aclk, aresetn, cmd.ld_end |=> state_reg == hrdp_pkg::ST_CLEAR, "no clearing pass after end record")
    `HRDP_ASSERT_ONEHOT0(a_one_load, aclk, aresetn, {cmd.ld_field, cmd.ld_use, cmd.ld_err, cmd.ld_end}, "several result loads at once")
    `HRDP_ASSERT(a_load_when_free, aclk, aresetn, (cmd.ld_field || cmd.ld_use || cmd.ld_err || cmd.ld_end) |-> st.out_free, "result register overwritten")

endmodule

/* rtl/core/hid_report_descriptor_parser.sv */
// HID report descriptor parser top level: byte stream in, field/usage records out.
// Each byte is accepted, then decoded; Input/Output/Feature items then read the bit
// count memory, load the field record, multiply size by count, write the sum back,
// then read and load each listed usage. Errors and the end record load one record
// each; any record load waits out an output stall. Reset (and every final byte)
// starts a bit count memory clearing pass, accepting no byte. Uses hrdp_pkg.
module hid_report_descriptor_parser #(
    parameter int STACK_DEPTH = hrdp_pkg::STACK_DEPTH_DEF,
    parameter int MAX_USAGES  = hrdp_pkg::MAX_USAGES_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,  // [7:0] descriptor_byte
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [1:0] direction, [9:2] report_ident, [25:10] bit_offset, [57:26] bit_size,
    // [89:58] element_count, [105:90] usage_page, [137:106] usage_low,
    // [169:138] usage_high, [201:170] logical_low, [233:202] logical_high
    output logic [239:0] m_tdata,
    output logic [2:0]   m_tuser,  // [2:0] record_kind
    output logic         m_tlast
);

    hrdp_pkg::dp_cmd_t    cmd;
    hrdp_pkg::dp_status_t st;

    hrdp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    hrdp_datapath #(
        .STACK_DEPTH (STACK_DEPTH),
        .MAX_USAGES  (MAX_USAGES)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .st       (st),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
